// ===== rtl/srx_pkg.sv =====
// shared types and constants of the stop and wait frame receiver
package srx_pkg;

  localparam int MAX_PAYLOAD = 2048;
  localparam int COUNT_W = 12;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int COUNT_CAP = (MAX_PAYLOAD < COUNT_MAX) ? MAX_PAYLOAD : COUNT_MAX;

  localparam logic [7:0] UNSTUFF_ESC = 8'h5D;
  localparam logic [7:0] UNSTUFF_FLAG = 8'h5E;
  localparam logic [7:0] CHECK_INIT = 8'h00;

  localparam logic [2:0] CFG_FLAG = 3'd0;
  localparam logic [2:0] CFG_ESCAPE = 3'd1;
  localparam logic [2:0] CFG_ADDRESS = 3'd2;
  localparam logic [2:0] CFG_INFO0 = 3'd3;
  localparam logic [2:0] CFG_INFO1 = 3'd4;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_NEW = 2'd1;
  localparam logic [1:0] KIND_DUP = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [1:0] RESP_RR0 = 2'd0;
  localparam logic [1:0] RESP_RR1 = 2'd1;
  localparam logic [1:0] RESP_REJ0 = 2'd2;
  localparam logic [1:0] RESP_REJ1 = 2'd3;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] sender_address;
    logic [7:0] info0_control;
    logic [7:0] info1_control;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [1:0] response_code;
    logic [COUNT_W-1:0] payload_count;
  } result_t;

  typedef enum logic [4:0] {
    ST_HUNT = 5'b00001,
    ST_AFTER_FLAG = 5'b00010,
    ST_ADDR_SEEN = 5'b00100,
    ST_CTRL_SEEN = 5'b01000,
    ST_DATA = 5'b10000
  } state_t;

endpackage

// ===== rtl/srx_cfg.sv =====
// configuration register file of the frame receiver
module srx_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  output srx_pkg::cfg_t  cfg
);
  import srx_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value <= 8'h7E;
      cfg.escape_value <= 8'h7D;
      cfg.sender_address <= 8'h03;
      cfg.info0_control <= 8'h00;
      cfg.info1_control <= 8'h40;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FLAG: cfg.flag_value <= cfg_data;
        CFG_ESCAPE: cfg.escape_value <= cfg_data;
        CFG_ADDRESS: cfg.sender_address <= cfg_data;
        CFG_INFO0: cfg.info0_control <= cfg_data;
        CFG_INFO1: cfg.info1_control <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/srx_core.sv =====
// input register and per-byte frame state update of the frame receiver
module srx_core (
  input  logic              clk,
  input  logic              rst,
  input  srx_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              res_free,
  output logic              res_load,
  output srx_pkg::result_t  res
);
  import srx_pkg::*;

  logic               in_valid_q;
  logic [7:0]         rx_q;
  logic               fire;

  state_t             state, state_next;
  logic               frame_seq, frame_seq_next;
  logic               exp_seq, exp_seq_next;
  logic               esc, esc_next;
  logic [7:0]         chk, chk_next;
  logic [7:0]         held_byte, held_byte_next;
  logic               held_valid, held_valid_next;
  logic [COUNT_W-1:0] count, count_next;

  logic               take;
  logic [7:0]         take_val;
  logic [7:0]         ctrl_sel;
  logic               emit;

  assign in_stall = in_valid_q && !res_free;
  assign fire = in_valid_q && res_free;
  assign ctrl_sel = frame_seq ? cfg.info1_control : cfg.info0_control;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rx_q <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      state <= ST_HUNT;
      frame_seq <= 1'b0;
      exp_seq <= 1'b0;
      esc <= 1'b0;
      chk <= CHECK_INIT;
      held_byte <= 8'h00;
      held_valid <= 1'b0;
      count <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        state <= state_next;
        frame_seq <= frame_seq_next;
        exp_seq <= exp_seq_next;
        esc <= esc_next;
        chk <= chk_next;
        held_byte <= held_byte_next;
        held_valid <= held_valid_next;
        count <= count_next;
      end
    end
  end

  always_comb begin
    state_next = state;
    frame_seq_next = frame_seq;
    exp_seq_next = exp_seq;
    esc_next = esc;
    chk_next = chk;
    held_byte_next = held_byte;
    held_valid_next = held_valid;
    count_next = count;
    take = 1'b0;
    take_val = rx_q;
    emit = 1'b0;
    res = '0;

    unique case (state)
      ST_HUNT: begin
        if (rx_q == cfg.flag_value) state_next = ST_AFTER_FLAG;
      end
      ST_AFTER_FLAG: begin
        if (rx_q == cfg.sender_address) state_next = ST_ADDR_SEEN;
        else if (rx_q == cfg.flag_value) state_next = ST_AFTER_FLAG;
        else state_next = ST_HUNT;
      end
      ST_ADDR_SEEN: begin
        if (rx_q == cfg.info0_control) begin
          frame_seq_next = 1'b0;
          state_next = ST_CTRL_SEEN;
        end else if (rx_q == cfg.info1_control) begin
          frame_seq_next = 1'b1;
          state_next = ST_CTRL_SEEN;
        end else if (rx_q == cfg.flag_value) begin
          state_next = ST_AFTER_FLAG;
        end else begin
          state_next = ST_HUNT;
        end
      end
      ST_CTRL_SEEN: begin
        if (rx_q == (cfg.sender_address ^ ctrl_sel)) begin
          state_next = ST_DATA;
          esc_next = 1'b0;
          chk_next = CHECK_INIT;
          held_valid_next = 1'b0;
          held_byte_next = 8'h00;
          count_next = '0;
        end else if (rx_q == cfg.flag_value) begin
          state_next = ST_AFTER_FLAG;
        end else begin
          state_next = ST_HUNT;
        end
      end
      ST_DATA: begin
        if (rx_q == cfg.flag_value) begin
          emit = 1'b1;
          if (chk == 8'h00) begin
            res.payload_count = count;
            if (frame_seq == exp_seq) begin
              res.kind = KIND_NEW;
              exp_seq_next = !exp_seq;
              res.response_code = exp_seq ? RESP_RR0 : RESP_RR1;
            end else begin
              res.kind = KIND_DUP;
              res.response_code = exp_seq ? RESP_RR1 : RESP_RR0;
            end
          end else begin
            res.kind = KIND_REJECT;
            res.response_code = exp_seq ? RESP_REJ1 : RESP_REJ0;
          end
          state_next = ST_HUNT;
          esc_next = 1'b0;
          held_valid_next = 1'b0;
          held_byte_next = 8'h00;
          chk_next = CHECK_INIT;
          count_next = '0;
        end else if (esc) begin
          esc_next = 1'b0;
          if (rx_q == UNSTUFF_ESC) begin
            take = 1'b1;
            take_val = cfg.escape_value;
          end else if (rx_q == UNSTUFF_FLAG) begin
            take = 1'b1;
            take_val = cfg.flag_value;
          end
        end else if (rx_q == cfg.escape_value) begin
          esc_next = 1'b1;
        end else begin
          take = 1'b1;
          take_val = rx_q;
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase

    if (take) begin
      if (held_valid) begin
        emit = 1'b1;
        res.kind = KIND_PAYLOAD;
        res.payload_byte = held_byte;
        if (count < COUNT_W'(COUNT_CAP)) count_next = count + 1'b1;
      end
      held_byte_next = take_val;
      held_valid_next = 1'b1;
      chk_next = chk ^ take_val;
    end
  end

  assign res_load = fire && emit;

endmodule

// ===== rtl/srx_out.sv =====
// result register of the frame receiver
module srx_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_load,
  input  srx_pkg::result_t            res,
  output logic                        res_free,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [7:0]                  payload_byte,
  output logic [1:0]                  response_code,
  output logic [srx_pkg::COUNT_W-1:0] payload_count
);
  import srx_pkg::*;

  result_t res_q;

  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign kind = res_q.kind;
  assign payload_byte = res_q.payload_byte;
  assign response_code = res_q.response_code;
  assign payload_count = res_q.payload_count;

endmodule

// ===== rtl/stop_and_wait_frame_receiver_unit.sv =====
// stop and wait frame receiver: flag hunt, header check, destuffing, frame status
// a beat is captured in the input register, then processed from there into the result
// register, from which its result beat, if any, is offered
// throughput: one input beat per cycle, limited only by the single result register
// reset: synchronous active-high rst clears the frame state, the expected sequence
// and both valid flags, and loads the configuration defaults
module stop_and_wait_frame_receiver_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [7:0]                  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [7:0]                  payload_byte,
  output logic [1:0]                  response_code,
  output logic [srx_pkg::COUNT_W-1:0] payload_count
);
  import srx_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_load;
  logic    res_free;

  srx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srx_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .res_free (res_free),
    .res_load (res_load),
    .res      (res)
  );

  srx_out u_out (
    .clk           (clk),
    .rst           (rst),
    .res_load      (res_load),
    .res           (res),
    .res_free      (res_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .response_code (response_code),
    .payload_count (payload_count)
  );

endmodule

// ===== tb/frame_rx_checker.sv =====
// frame receiver checker: watches the channels, predicts result beats and compares them
`timescale 1ns / 1ps

module frame_rx_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [7:0]                  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [1:0]                  kind,
  input  logic [7:0]                  payload_byte,
  input  logic [1:0]                  response_code,
  input  logic [srx_pkg::COUNT_W-1:0] payload_count,
  output int                          pending,
  output int                          errors
);
  import srx_pkg::*;

  cfg_t rx_cfg;
  state_t rx_state;
  logic frame_seq;
  logic seq_expected;
  logic esc_pending;
  logic [7:0] running_check;
  logic [7:0] held;
  logic held_ok;
  logic [COUNT_W-1:0] emitted;
  result_t expected_beats[$];

  task automatic report_mismatch(input string field, input int got_v, input int exp_v);
    $display("mismatch on %s: got %0d, expected %0d", field, got_v, exp_v);
    errors++;
  endtask

  task automatic push_beat(input logic [1:0] k, input logic [7:0] d, input logic [1:0] code,
                           input logic [COUNT_W-1:0] cnt);
    result_t r;
    r.kind = k;
    r.payload_byte = d;
    r.response_code = code;
    r.payload_count = cnt;
    expected_beats.push_back(r);
  endtask

  // emit the held byte, hold the new one
  task automatic take_payload(input logic [7:0] d);
    if (held_ok) begin
      push_beat(KIND_PAYLOAD, held, RESP_RR0, '0);
      if (emitted < COUNT_CAP) emitted++;
    end
    held = d;
    held_ok = 1'b1;
    running_check ^= d;
  endtask

  task automatic receive_line_byte(input logic [7:0] b);
    logic [7:0] ctrl;
    case (rx_state)
      ST_HUNT: begin
        if (b == rx_cfg.flag_value) rx_state = ST_AFTER_FLAG;
      end
      ST_AFTER_FLAG: begin
        if (b == rx_cfg.sender_address) rx_state = ST_ADDR_SEEN;
        else if (b == rx_cfg.flag_value) rx_state = ST_AFTER_FLAG;
        else rx_state = ST_HUNT;
      end
      ST_ADDR_SEEN: begin
        if (b == rx_cfg.info0_control) begin
          frame_seq = 1'b0;
          rx_state = ST_CTRL_SEEN;
        end else if (b == rx_cfg.info1_control) begin
          frame_seq = 1'b1;
          rx_state = ST_CTRL_SEEN;
        end else if (b == rx_cfg.flag_value) begin
          rx_state = ST_AFTER_FLAG;
        end else begin
          rx_state = ST_HUNT;
        end
      end
      ST_CTRL_SEEN: begin
        ctrl = frame_seq ? rx_cfg.info1_control : rx_cfg.info0_control;
        if (b == (rx_cfg.sender_address ^ ctrl)) begin
          rx_state = ST_DATA;
          esc_pending = 1'b0;
          running_check = CHECK_INIT;
          held_ok = 1'b0;
          held = '0;
          emitted = '0;
        end else if (b == rx_cfg.flag_value) begin
          rx_state = ST_AFTER_FLAG;
        end else begin
          rx_state = ST_HUNT;
        end
      end
      ST_DATA: begin
        if (b == rx_cfg.flag_value) begin
          if (running_check != 8'h00) begin
            push_beat(KIND_REJECT, '0, seq_expected ? RESP_REJ1 : RESP_REJ0, '0);
          end else if (frame_seq == seq_expected) begin
            seq_expected = ~seq_expected;
            push_beat(KIND_NEW, '0, seq_expected ? RESP_RR1 : RESP_RR0, emitted);
          end else begin
            push_beat(KIND_DUP, '0, seq_expected ? RESP_RR1 : RESP_RR0, emitted);
          end
          rx_state = ST_HUNT;
          esc_pending = 1'b0;
          held_ok = 1'b0;
          held = '0;
          running_check = CHECK_INIT;
          emitted = '0;
        end else if (esc_pending) begin
          esc_pending = 1'b0;
          if (b == UNSTUFF_ESC) take_payload(rx_cfg.escape_value);
          else if (b == UNSTUFF_FLAG) take_payload(rx_cfg.flag_value);
        end else if (b == rx_cfg.escape_value) begin
          esc_pending = 1'b1;
        end else begin
          take_payload(b);
        end
      end
      default: rx_state = ST_HUNT;
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      rx_cfg = '{8'h7E, 8'h7D, 8'h03, 8'h00, 8'h40};
      rx_state = ST_HUNT;
      frame_seq = 1'b0;
      seq_expected = 1'b0;
      esc_pending = 1'b0;
      running_check = CHECK_INIT;
      held = '0;
      held_ok = 1'b0;
      emitted = '0;
      expected_beats.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FLAG:    rx_cfg.flag_value = cfg_data;
          CFG_ESCAPE:  rx_cfg.escape_value = cfg_data;
          CFG_ADDRESS: rx_cfg.sender_address = cfg_data;
          CFG_INFO0:   rx_cfg.info0_control = cfg_data;
          CFG_INFO1:   rx_cfg.info1_control = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) receive_line_byte(rx_byte);
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat, kind", int'(kind), -1);
        end else begin
          want = expected_beats.pop_front();
          if (kind !== want.kind) report_mismatch("kind", int'(kind), int'(want.kind));
          if (payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", int'(payload_byte), int'(want.payload_byte));
          if (response_code !== want.response_code)
            report_mismatch("response_code", int'(response_code), int'(want.response_code));
          if (payload_count !== want.payload_count)
            report_mismatch("payload_count", int'(payload_count), int'(want.payload_count));
        end
      end
    end
    pending <= expected_beats.size();
  end

endmodule

// ===== tb/tb.sv =====
// testbench top: drives line bytes and register writes into the frame receiver
`timescale 1ns / 1ps

module tb;
  import srx_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_FLAG;
  logic [7:0] cfg_data = 8'h00;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [1:0] response_code;
  logic [COUNT_W-1:0] payload_count;
  int pending;
  int errors;

  cfg_t line_cfg = '{8'h7E, 8'h7D, 8'h03, 8'h00, 8'h40};
  bit steady = 1'b0;
  int sent_bytes = 0;
  int stall_left = 0;
  int flow_left = 0;

  // header quirks, stuffing, an invalid escape pair, empty frame, duplicate frame
  logic [7:0] opening [27] = '{
    8'h7E, 8'h7E, 8'h03, 8'h55,
    8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'hFF, 8'h7D, 8'h5D, 8'h7D, 8'h5E,
    8'h7D, 8'h11, 8'hFC, 8'h7E,
    8'h7E, 8'h03, 8'h40, 8'h43, 8'h7E,
    8'h7E, 8'h03, 8'h40, 8'h43
  };

  always #2 clk = ~clk;

  stop_and_wait_frame_receiver_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .payload_byte(payload_byte),
    .response_code(response_code), .payload_count(payload_count)
  );

  frame_rx_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .payload_byte(payload_byte),
    .response_code(response_code), .payload_count(payload_count),
    .pending(pending), .errors(errors)
  );

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (flow_left > 0) begin
      flow_left--;
      out_stall <= 1'b0;
    end else begin
      flow_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
      stall_left = gap_length();
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == line_cfg.flag_value || b == line_cfg.escape_value) begin
      send_byte(line_cfg.escape_value);
      send_byte((b == line_cfg.flag_value) ? UNSTUFF_FLAG : UNSTUFF_ESC);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed frames; some broken headers, bad checks, noise and junk escapes
  task automatic send_frame(input int len, input bit clean);
    int r;
    int r2;
    int i;
    logic seq;
    logic [7:0] ctrl;
    logic [7:0] chk;
    logic [7:0] b;
    logic [7:0] junk;
    if (!clean && $urandom_range(0, 19) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    seq = 1'($urandom_range(0, 1));
    ctrl = seq ? line_cfg.info1_control : line_cfg.info0_control;
    r = clean ? 99 : $urandom_range(0, 99);
    send_byte(line_cfg.flag_value);
    if (r < 3) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_byte(line_cfg.sender_address);
    if (r < 6) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_byte(ctrl);
    if (r < 9) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_byte(line_cfg.sender_address ^ ctrl);
    chk = CHECK_INIT;
    for (i = 0; i < len; i++) begin
      if (!clean && $urandom_range(0, 19) == 0) begin
        junk = 8'($urandom_range(0, 255));
        while (junk == UNSTUFF_ESC || junk == UNSTUFF_FLAG || junk == line_cfg.flag_value)
          junk = 8'($urandom_range(0, 255));
        send_byte(line_cfg.escape_value);
        send_byte(junk);
      end
      r2 = $urandom_range(0, 99);
      if (r2 < 8) b = line_cfg.flag_value;
      else if (r2 < 16) b = line_cfg.escape_value;
      else if (r2 < 20) b = UNSTUFF_ESC;
      else if (r2 < 24) b = UNSTUFF_FLAG;
      else b = 8'($urandom_range(0, 255));
      send_stuffed(b);
      chk ^= b;
    end
    r = clean ? 99 : $urandom_range(0, 99);
    if (r < 15) chk ^= 8'($urandom_range(1, 255));
    send_stuffed(chk);
    if (r >= 15 && r < 23) send_byte(line_cfg.escape_value);
    send_byte(line_cfg.flag_value);
  endtask

  initial begin
    int phase;
    int target;
    cfg_t s;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (opening[i]) send_byte(opening[i]);
    send_byte(8'h7E);
    for (phase = 0; phase < 7; phase++) begin
      settle();
      case (phase)
        0: s = '{8'h7E, 8'h7D, 8'h03, 8'h00, 8'h40};
        1: s = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        2: s = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
        default: begin
          s.flag_value = 8'($urandom_range(0, 255));
          s.escape_value = s.flag_value ^ 8'($urandom_range(1, 255));
          s.sender_address = 8'($urandom_range(0, 255));
          s.info0_control = 8'($urandom_range(0, 255));
          s.info1_control = 8'($urandom_range(0, 255));
          if (phase == 3) s.info1_control = s.info0_control;
          if (phase == 4) s.escape_value = s.flag_value;
        end
      endcase
      write_reg(CFG_FLAG, s.flag_value);
      write_reg(CFG_ESCAPE, s.escape_value);
      write_reg(CFG_ADDRESS, s.sender_address);
      write_reg(CFG_INFO0, s.info0_control);
      write_reg(CFG_INFO1, s.info1_control);
      cfg_valid <= 1'b0;
      line_cfg = s;
      steady = (phase % 3 == 2);
      target = sent_bytes + ((phase == 4) ? 30 : 90);
      while (sent_bytes < target)
        send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12),
                   1'b0);
      // one frame past the count limit
      if (phase == 5) send_frame(COUNT_CAP + 12, 1'b1);
    end
    settle();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
